// ----- sv/grj_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared constants, widths, register codes and the result beat type
// of the gaussian residual / jacobian evaluator; no dependencies

package grj_pkg;

   localparam int HALF_WIDTH_MAX = 15;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X   = 3'd0,
      CSR_CENTER_Y   = 3'd1,
      CSR_AMPLITUDE  = 3'd2,
      CSR_SIGMA      = 3'd3,
      CSR_OFFSET     = 3'd4,
      CSR_HALF_WIDTH = 3'd5,
      CSR_FIT_MASK   = 3'd6
   } csr_idx_type;

   // fit_mask bit positions
   localparam int FIT_X   = 0;
   localparam int FIT_Y   = 1;
   localparam int FIT_AMP = 2;
   localparam int FIT_SIG = 3;
   localparam int FIT_OFS = 4;

   localparam int CENTER_W = 24;
   localparam int AMP_W    = 32;
   localparam int SIGMA_W  = 24;
   localparam int HW_W     = 4;
   localparam int MASK_W   = 5;

   localparam int COORD_W = 5;
   localparam int PIX_W   = 16;

   localparam int ABS_W   = 24;  // |xi|, |yi| in Q.16
   localparam int SQ_W    = 48;  // xi^2
   localparam int R2_W    = 49;  // xi^2 + yi^2 in Q.32
   localparam int S2_W    = 48;  // sigma^2
   localparam int D_W     = 49;  // 2 * sigma^2
   localparam int S3_W    = 72;  // sigma^3
   localparam int G_W     = 17;  // gaussian in Q1.16
   localparam int PG_W    = 48;  // |A| * g
   localparam int RES_W   = 40;
   localparam int DERIV_W = 48;

   localparam int U_W          = 31;  // exponent argument in Q0.31
   localparam int SUM_W        = 32;
   localparam int UDIV_STAGES  = 31;
   localparam int TAYLOR_TERMS = 12;
   localparam int SQUARINGS    = 5;
   localparam int RECIP_SHIFT  = 35;
   localparam int RECIP_W      = 36;

   localparam int EXP_LAT  = 1 + UDIV_STAGES + 3 * TAYLOR_TERMS + SQUARINGS + 1;
   localparam int QDIV_BITS = 48;
   localparam int QDIV_LAT  = QDIV_BITS + 2;

   // floor(2^35 / k) for the taylor term divide
   function automatic logic [RECIP_W-1:0] recip_q35(input int k);
      logic [RECIP_W-1:0] r;
      case (k)
         1:       r = 36'd34359738368;
         2:       r = 36'd17179869184;
         3:       r = 36'd11453246122;
         4:       r = 36'd8589934592;
         5:       r = 36'd6871947673;
         6:       r = 36'd5726623061;
         7:       r = 36'd4908534052;
         8:       r = 36'd4294967296;
         9:       r = 36'd3817748707;
         10:      r = 36'd3435973836;
         11:      r = 36'd3123612578;
         12:      r = 36'd2863311530;
         default: r = 36'd0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic [RES_W-1:0]   residual;
      logic [DERIV_W-1:0] deriv_center_x;
      logic [DERIV_W-1:0] deriv_center_y;
      logic [G_W-1:0]     deriv_amplitude;
      logic [DERIV_W-1:0] deriv_sigma;
      logic               deriv_offset;
      logic               last_out;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/grj_exp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// pipelined gaussian exp(-r2/d) in Q1.16: restoring divide, taylor series, squarings
// depends on grj_pkg

module grj_exp (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [grj_pkg::R2_W-1:0]    r2,
   input  wire logic [grj_pkg::D_W-1:0]     den,
   output logic      [grj_pkg::G_W-1:0]     g
);

   localparam int DS  = grj_pkg::UDIV_STAGES;
   localparam int UW  = grj_pkg::U_W;
   localparam int DW  = grj_pkg::D_W;
   localparam int SW  = grj_pkg::SUM_W;
   localparam int NT  = grj_pkg::TAYLOR_TERMS;
   localparam int NS  = grj_pkg::SQUARINGS;
   localparam int RW  = grj_pkg::RECIP_W;
   localparam int RS  = grj_pkg::RECIP_SHIFT;
   localparam int GW  = grj_pkg::G_W;

   // ---- divide: u = floor(r2 * 2^26 / d) ----
   logic [DW-1:0] rem_ff [0:DS];
   logic [UW-1:0] w_ff   [0:DS];
   logic          z_ff   [0:DS];

   logic [DW-1:0] rem0_in;
   logic [UW-1:0] w0_in;
   logic          z0_in;

   // at or past r2 = 32 * d, that is 64 sigma squared, the gaussian is zero
   assign z0_in   = ({5'd0, r2} >= {den, 5'd0});
   assign rem0_in = DW'(r2 >> 5);
   assign w0_in   = {r2[4:0], 26'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         w_ff[0]   <= w0_in;
         z_ff[0]   <= z0_in;
      end
   end

   for (genvar j = 1; j <= DS; j++) begin : g_div
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [UW-1:0] w_in;
      assign trial  = {rem_ff[j-1], w_ff[j-1][UW-1]};
      assign ge     = (trial >= {1'b0, den});
      assign rem_in = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
      assign w_in   = {w_ff[j-1][UW-2:0], ge};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            w_ff[j]   <= w_in;
            z_ff[j]   <= z_ff[j-1];
         end
      end
   end

   // ---- taylor series of exp(-u), three stages per term ----
   logic [SW-1:0] term_w [0:NT];
   logic [UW-1:0] u_w    [0:NT];
   logic [SW-1:0] sum_w  [0:NT];
   logic          z_w    [0:NT];

   assign term_w[0] = SW'(1) << 31;
   assign sum_w[0]  = SW'(1) << 31;
   assign u_w[0]    = w_ff[DS];
   assign z_w[0]    = z_ff[DS];

   for (genvar k = 1; k <= NT; k++) begin : g_term
      localparam logic [RW-1:0] RECIP = grj_pkg::recip_q35(k);
      localparam bit            ODD   = (k % 2) == 1;

      logic [UW-1:0] ta_ff, ua_ff, tb_ff, qh_ff, ub_ff, uc_ff;
      logic [SW-1:0] sa_ff, sb_ff, sc_ff, term_ff;
      logic          za_ff, zb_ff, zc_ff;

      logic [UW-1:0] ta_in, qh_in, q_in;
      logic [SW-1:0] sc_in;
      logic [RW-1:0] back;
      logic          fix;

      assign ta_in = UW'((63'(term_w[k-1]) * 63'(u_w[k-1])) >> 31);
      assign qh_in = UW'((67'(ta_ff) * 67'(RECIP)) >> RS);
      // estimate is low by at most one
      assign back  = RW'(qh_ff) * RW'(k);
      assign fix   = (RW'(tb_ff) - back) >= RW'(k);
      assign q_in  = qh_ff + UW'(fix);
      assign sc_in = ODD ? (sb_ff - SW'(q_in)) : (sb_ff + SW'(q_in));

      always_ff @(posedge clock) begin
         if (en) begin
            ta_ff   <= ta_in;
            ua_ff   <= u_w[k-1];
            sa_ff   <= sum_w[k-1];
            za_ff   <= z_w[k-1];
            tb_ff   <= ta_ff;
            qh_ff   <= qh_in;
            ub_ff   <= ua_ff;
            sb_ff   <= sa_ff;
            zb_ff   <= za_ff;
            term_ff <= SW'(q_in);
            sc_ff   <= sc_in;
            uc_ff   <= ub_ff;
            zc_ff   <= zb_ff;
         end
      end

      assign term_w[k] = term_ff;
      assign sum_w[k]  = sc_ff;
      assign u_w[k]    = uc_ff;
      assign z_w[k]    = zc_ff;
   end

   // ---- five squarings in Q.31, round half up ----
   logic [SW-1:0] sq_w  [0:NS];
   logic          sqz_w [0:NS];

   assign sq_w[0]  = sum_w[NT];
   assign sqz_w[0] = z_w[NT];

   for (genvar i = 1; i <= NS; i++) begin : g_sq
      logic [SW-1:0] sq_ff, sq_in;
      logic          sqz_ff;
      assign sq_in = SW'((64'(sq_w[i-1]) * 64'(sq_w[i-1]) + 64'h4000_0000) >> 31);
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff  <= sq_in;
            sqz_ff <= sqz_w[i-1];
         end
      end
      assign sq_w[i]  = sq_ff;
      assign sqz_w[i] = sqz_ff;
   end

   logic [SW:0]   gr;
   logic [GW-1:0] g_ff, g_in;

   assign gr   = (33'(sq_w[NS]) + 33'h4000) >> 15;
   assign g_in = sqz_w[NS] ? '0 :
                 (gr > 33'd65536) ? GW'(65536) : GW'(gr);

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff <= g_in;
      end
   end

   assign g = g_ff;

endmodule

`default_nettype wire

// ----- sv/grj_qdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider: round(num/den) ties away, signed, saturated to 48 bits
// depends on grj_pkg

module grj_qdiv #(
   parameter int NUM_W = 80,
   parameter int DEN_W = 48
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [NUM_W-1:0]               num,
   input  wire logic [DEN_W-1:0]               den,
   input  wire logic                           neg,
   output logic      [grj_pkg::DERIV_W-1:0]    quo
);

   localparam int QB   = grj_pkg::QDIV_BITS;
   localparam int HI_W = NUM_W - QB;
   localparam int MW   = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [0:QB];
   logic [QB-1:0]    w_ff   [0:QB];
   logic             ovf_ff [0:QB];
   logic             neg_ff [0:QB];

   logic             ovf0_in;

   // quotient needs more than 48 bits: saturate
   assign ovf0_in = (MW'(num[NUM_W-1:QB]) >= MW'(den));

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num[NUM_W-1:QB]);
         w_ff[0]   <= num[QB-1:0];
         ovf_ff[0] <= ovf0_in;
         neg_ff[0] <= neg;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [QB-1:0]    w_in;
      assign trial  = {rem_ff[j-1], w_ff[j-1][QB-1]};
      assign ge     = (trial >= {1'b0, den});
      assign rem_in = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      assign w_in   = {w_ff[j-1][QB-2:0], ge};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            w_ff[j]   <= w_in;
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   localparam logic [QB-1:0] LIM_POS = {1'b0, {(QB-1){1'b1}}};
   localparam logic [QB-1:0] LIM_NEG = {1'b1, {(QB-1){1'b0}}};

   logic          rb;
   logic [QB:0]   qr;
   logic [QB-1:0] lim, mag, quo_ff, quo_in;

   assign rb     = ({rem_ff[QB], 1'b0} >= {1'b0, den});
   assign qr     = (QB+1)'(w_ff[QB]) + (QB+1)'(rb);
   assign lim    = neg_ff[QB] ? LIM_NEG : LIM_POS;
   assign mag    = (ovf_ff[QB] || (qr > {1'b0, lim})) ? lim : QB'(qr);
   assign quo_in = neg_ff[QB] ? (~mag + 1'b1) : mag;

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// ----- sv/gaussian_2d_residual_jacobian.sv -----
`timescale 1ns / 1ps
`default_nettype none
// gaussian spot model: residual and jacobian row for one window pixel
// depends on grj_pkg, grj_exp, grj_qdiv
//
//   port group  dir  beat taken when          carries
//   req_*       in   req_valid & !req_stall   column, row, pixel_value, is_last
//   rsp_*       out  rsp_valid & !rsp_stall   residual, derivatives, last_out
//   csr_*       in   csr_write_en             csr_index, csr_wdata
//
// one pixel per cycle while req_stall is low; each pixel passes the input stages, the
// 74-stage exponential unit, the product stages and the 50-stage rounding dividers
// before its result enters the output buffer and rsp_valid rises
// reset clears the registers to their defaults and empties the pipeline
// a 2-entry output buffer takes results while rsp is stalled; req stalls
// only when that buffer is full, and the whole pipeline holds with it

module gaussian_2d_residual_jacobian (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               csr_write_en,
   input  wire logic [grj_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [grj_pkg::CSR_DATA_W-1:0]     csr_wdata,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [grj_pkg::COORD_W-1:0]        req_column,
   input  wire logic [grj_pkg::COORD_W-1:0]        req_row,
   input  wire logic [grj_pkg::PIX_W-1:0]          req_pixel_value,
   input  wire logic                               req_is_last,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [grj_pkg::RES_W-1:0]          rsp_residual,
   output logic      [grj_pkg::DERIV_W-1:0]        rsp_deriv_center_x,
   output logic      [grj_pkg::DERIV_W-1:0]        rsp_deriv_center_y,
   output logic      [grj_pkg::G_W-1:0]            rsp_deriv_amplitude,
   output logic      [grj_pkg::DERIV_W-1:0]        rsp_deriv_sigma,
   output logic                                    rsp_deriv_offset,
   output logic                                    rsp_last_out
);

   localparam int EL  = grj_pkg::EXP_LAT;
   localparam int QL  = grj_pkg::QDIV_LAT;
   localparam int AW  = grj_pkg::ABS_W;
   localparam int R2W = grj_pkg::R2_W;
   localparam int PW  = grj_pkg::PIX_W;
   localparam int S2W = grj_pkg::S2_W;
   localparam int S3W = grj_pkg::S3_W;
   localparam int GW  = grj_pkg::G_W;
   localparam int PGW = grj_pkg::PG_W;
   localparam int RW  = grj_pkg::RES_W;
   localparam int NXW = PGW + AW;          // 72
   localparam int NSW = PGW + R2W;         // 97

   // ---------------- configuration ----------------
   logic [grj_pkg::CENTER_W-1:0] center_x_ff, center_y_ff;
   logic [grj_pkg::AMP_W-1:0]    amplitude_ff, offset_ff;
   logic [grj_pkg::SIGMA_W-1:0]  sigma_ff;
   logic [grj_pkg::HW_W-1:0]     half_width_ff;
   logic [grj_pkg::MASK_W-1:0]   fit_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         amplitude_ff  <= 32'd256;
         sigma_ff      <= 24'd65536;
         offset_ff     <= '0;
         half_width_ff <= 4'd3;
         fit_mask_ff   <= 5'd31;
      end else if (csr_write_en) begin
         unique case (grj_pkg::csr_idx_type'(csr_index))
            grj_pkg::CSR_CENTER_X:   center_x_ff   <= csr_wdata[23:0];
            grj_pkg::CSR_CENTER_Y:   center_y_ff   <= csr_wdata[23:0];
            grj_pkg::CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata;
            grj_pkg::CSR_SIGMA:      sigma_ff      <= csr_wdata[23:0];
            grj_pkg::CSR_OFFSET:     offset_ff     <= csr_wdata;
            grj_pkg::CSR_HALF_WIDTH: half_width_ff <= csr_wdata[3:0];
            grj_pkg::CSR_FIT_MASK:   fit_mask_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // derived terms follow the registers through s2_ff, then s3lo_ff and s3hi_ff, then s3_ff
   logic [grj_pkg::SIGMA_W-1:0] sig_eff;
   logic [S2W-1:0]              s2_ff, s2_in, s3lo_ff, s3hi_ff;
   logic [S3W-1:0]              s3_ff, s3_in;

   assign sig_eff = (sigma_ff == '0) ? 24'd1 : sigma_ff;
   assign s2_in   = S2W'(sig_eff) * S2W'(sig_eff);
   assign s3_in   = S3W'(s3lo_ff) + (S3W'(s3hi_ff) << 24);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff   <= 48'h1_0000_0000;
         s3lo_ff <= '0;
         s3hi_ff <= 48'h100_0000;
         s3_ff   <= 72'h1_0000_0000_0000;
      end else begin
         s2_ff   <= s2_in;
         s3lo_ff <= S2W'(s2_ff[23:0]) * S2W'(sig_eff);
         s3hi_ff <= S2W'(s2_ff[47:24]) * S2W'(sig_eff);
         s3_ff   <= s3_in;
      end
   end

   // ---------------- flow control ----------------
   logic [1:0] cnt_ff, cnt_in;
   logic       en;
   logic       push, pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = ~en;

   // ---------------- stage 1: input beat ----------------
   logic                         v1_ff, last1_ff;
   logic [grj_pkg::COORD_W-1:0]  col1_ff, row1_ff;
   logic [PW-1:0]                pix1_ff;

   // ---------------- stage 2: offsets ----------------
   logic [grj_pkg::HW_W-1:0] hw_eff;
   logic signed [6:0]        dcol, drow;
   logic signed [25:0]       xi, yi;
   logic                     v2_ff, last2_ff, sx2_ff, sy2_ff;
   logic [AW-1:0]            ax2_ff, ay2_ff, ax_in, ay_in;
   logic [PW-1:0]            pix2_ff;

   assign hw_eff = (32'(half_width_ff) > grj_pkg::HALF_WIDTH_MAX) ?
                   grj_pkg::HW_W'(grj_pkg::HALF_WIDTH_MAX) : half_width_ff;
   assign dcol   = $signed({2'b00, col1_ff}) - $signed({3'b000, hw_eff});
   assign drow   = $signed({2'b00, row1_ff}) - $signed({3'b000, hw_eff});
   assign xi     = $signed({{3{dcol[6]}}, dcol, 16'h0000})
                 - $signed({{2{center_x_ff[23]}}, center_x_ff});
   assign yi     = $signed({{3{drow[6]}}, drow, 16'h0000})
                 - $signed({{2{center_y_ff[23]}}, center_y_ff});
   assign ax_in  = AW'(xi[25] ? -xi : xi);
   assign ay_in  = AW'(yi[25] ? -yi : yi);

   // ---------------- stage 3: squares ----------------
   logic                     v3_ff, last3_ff, sx3_ff, sy3_ff;
   logic [AW-1:0]            ax3_ff, ay3_ff;
   logic [grj_pkg::SQ_W-1:0] xx3_ff, yy3_ff;
   logic [PW-1:0]            pix3_ff;

   // ---------------- stage 4: radius squared ----------------
   logic                     v4_ff, last4_ff, sx4_ff, sy4_ff;
   logic [AW-1:0]            ax4_ff, ay4_ff;
   logic [R2W-1:0]           r2_4_ff;
   logic [PW-1:0]            pix4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col1_ff  <= req_column;
         row1_ff  <= req_row;
         pix1_ff  <= req_pixel_value;
         last1_ff <= req_is_last;

         ax2_ff   <= ax_in;
         ay2_ff   <= ay_in;
         sx2_ff   <= xi[25];
         sy2_ff   <= yi[25];
         pix2_ff  <= pix1_ff;
         last2_ff <= last1_ff;

         xx3_ff   <= grj_pkg::SQ_W'(ax2_ff) * grj_pkg::SQ_W'(ax2_ff);
         yy3_ff   <= grj_pkg::SQ_W'(ay2_ff) * grj_pkg::SQ_W'(ay2_ff);
         ax3_ff   <= ax2_ff;
         ay3_ff   <= ay2_ff;
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;
         pix3_ff  <= pix2_ff;
         last3_ff <= last2_ff;

         r2_4_ff  <= R2W'(xx3_ff) + R2W'(yy3_ff);
         ax4_ff   <= ax3_ff;
         ay4_ff   <= ay3_ff;
         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;
         pix4_ff  <= pix3_ff;
         last4_ff <= last3_ff;
      end
   end

   // ---------------- gaussian unit, side data alongside ----------------
   typedef struct packed {
      logic [AW-1:0]  ax;
      logic [AW-1:0]  ay;
      logic           sx;
      logic           sy;
      logic [R2W-1:0] r2;
      logic [PW-1:0]  pix;
      logic           last;
   } side_type;

   logic [GW-1:0] g_exp;
   side_type      sd_ff  [0:EL-1];
   logic          sdv_ff [0:EL-1];

   grj_exp u_exp (
      .clock (clock),
      .en    (en),
      .r2    (r2_4_ff),
      .den   ({s2_ff, 1'b0}),
      .g     (g_exp)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= '{ax: ax4_ff, ay: ay4_ff, sx: sx4_ff, sy: sy4_ff,
                       r2: r2_4_ff, pix: pix4_ff, last: last4_ff};
         for (int i = 1; i < EL; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EL; i++) begin
            sdv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         sdv_ff[0] <= v4_ff;
         for (int i = 1; i < EL; i++) begin
            sdv_ff[i] <= sdv_ff[i-1];
         end
      end
   end

   // ---------------- P1: amplitude products ----------------
   logic                 amp_neg;
   logic [31:0]          amp_abs;
   logic                 p1v_ff;
   side_type             p1s_ff;
   logic [GW-1:0]        p1g_ff;
   logic [PGW-1:0]       pg_ff;
   logic signed [49:0]   ag_ff, ag_in;

   assign amp_neg = amplitude_ff[31];
   assign amp_abs = amp_neg ? (~amplitude_ff + 1'b1) : amplitude_ff;
   assign ag_in   = 50'($signed(amplitude_ff)) * 50'($signed({1'b0, g_exp}));

   // ---------------- P2: residual and numerator products ----------------
   logic signed [49:0]   ag_rnd;
   logic [RW-1:0]        res_in, res2_ff;
   logic                 p2v_ff, p2last_ff, p2sx_ff, p2sy_ff;
   logic [GW-1:0]        p2g_ff;
   logic [NXW-1:0]       nx2_ff, ny2_ff;
   logic [NXW:0]         nslo_ff;
   logic [NXW-1:0]       nshi_ff;

   assign ag_rnd = (ag_ff + 50'sd32768) >>> 16;
   // cannot leave 40 bits: |A*g| <= 2^31 counts plus offset and pixel
   assign res_in = RW'(ag_rnd) + RW'($signed(offset_ff)) - RW'({p1s_ff.pix, 8'h00});

   // ---------------- P3: sigma numerator sum, signs ----------------
   logic                 p3v_ff, p3last_ff, negx_ff, negy_ff, negs_ff;
   logic [RW-1:0]        res3_ff;
   logic [GW-1:0]        p3g_ff;
   logic [NXW-1:0]       nx3_ff, ny3_ff;
   logic [NSW-1:0]       ns3_ff, ns_in;

   assign ns_in = NSW'(nslo_ff) + (NSW'(nshi_ff) << 25);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
         p2v_ff <= 1'b0;
         p3v_ff <= 1'b0;
      end else if (en) begin
         p1v_ff <= sdv_ff[EL-1];
         p2v_ff <= p1v_ff;
         p3v_ff <= p2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1s_ff    <= sd_ff[EL-1];
         p1g_ff    <= g_exp;
         pg_ff     <= PGW'(amp_abs) * PGW'(g_exp);
         ag_ff     <= ag_in;

         res2_ff   <= res_in;
         p2g_ff    <= p1g_ff;
         p2last_ff <= p1s_ff.last;
         p2sx_ff   <= p1s_ff.sx;
         p2sy_ff   <= p1s_ff.sy;
         nx2_ff    <= NXW'(pg_ff) * NXW'(p1s_ff.ax);
         ny2_ff    <= NXW'(pg_ff) * NXW'(p1s_ff.ay);
         nslo_ff   <= (NXW+1)'(pg_ff) * (NXW+1)'(p1s_ff.r2[24:0]);
         nshi_ff   <= NXW'(pg_ff) * NXW'(p1s_ff.r2[48:25]);

         res3_ff   <= res2_ff;
         p3g_ff    <= p2g_ff;
         p3last_ff <= p2last_ff;
         nx3_ff    <= nx2_ff;
         ny3_ff    <= ny2_ff;
         ns3_ff    <= ns_in;
         negx_ff   <= amp_neg ^ p2sx_ff;
         negy_ff   <= amp_neg ^ p2sy_ff;
         negs_ff   <= amp_neg;
      end
   end

   // ---------------- rounding dividers ----------------
   logic [grj_pkg::DERIV_W-1:0] dx, dy, ds;

   grj_qdiv #(.NUM_W(NXW + 8), .DEN_W(S2W)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   ({nx3_ff, 8'h00}),
      .den   (s2_ff),
      .neg   (negx_ff),
      .quo   (dx)
   );

   grj_qdiv #(.NUM_W(NXW + 8), .DEN_W(S2W)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   ({ny3_ff, 8'h00}),
      .den   (s2_ff),
      .neg   (negy_ff),
      .quo   (dy)
   );

   grj_qdiv #(.NUM_W(NSW + 8), .DEN_W(S3W)) u_div_s (
      .clock (clock),
      .en    (en),
      .num   ({ns3_ff, 8'h00}),
      .den   (s3_ff),
      .neg   (negs_ff),
      .quo   (ds)
   );

   typedef struct packed {
      logic [RW-1:0] res;
      logic [GW-1:0] g;
      logic          last;
   } tail_type;

   tail_type qd_ff  [0:QL-1];
   logic     qdv_ff [0:QL-1];

   always_ff @(posedge clock) begin
      if (en) begin
         qd_ff[0] <= '{res: res3_ff, g: p3g_ff, last: p3last_ff};
         for (int i = 1; i < QL; i++) begin
            qd_ff[i] <= qd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QL; i++) begin
            qdv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         qdv_ff[0] <= p3v_ff;
         for (int i = 1; i < QL; i++) begin
            qdv_ff[i] <= qdv_ff[i-1];
         end
      end
   end

   // ---------------- output buffer ----------------
   grj_pkg::rsp_type beat_in;
   grj_pkg::rsp_type buf_ff [0:1];
   logic             wp_ff, rp_ff;

   always_comb begin
      beat_in.residual        = qd_ff[QL-1].res;
      beat_in.deriv_center_x  = fit_mask_ff[grj_pkg::FIT_X]   ? dx : '0;
      beat_in.deriv_center_y  = fit_mask_ff[grj_pkg::FIT_Y]   ? dy : '0;
      beat_in.deriv_amplitude = fit_mask_ff[grj_pkg::FIT_AMP] ? qd_ff[QL-1].g : '0;
      beat_in.deriv_sigma     = fit_mask_ff[grj_pkg::FIT_SIG] ? ds : '0;
      beat_in.deriv_offset    = fit_mask_ff[grj_pkg::FIT_OFS];
      beat_in.last_out        = qd_ff[QL-1].last;
   end

   assign push   = en & qdv_ff[QL-1];
   assign pop    = rsp_valid & ~rsp_stall;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wp_ff] <= beat_in;
      end
   end

   assign rsp_valid           = (cnt_ff != 2'd0);
   assign rsp_residual        = buf_ff[rp_ff].residual;
   assign rsp_deriv_center_x  = buf_ff[rp_ff].deriv_center_x;
   assign rsp_deriv_center_y  = buf_ff[rp_ff].deriv_center_y;
   assign rsp_deriv_amplitude = buf_ff[rp_ff].deriv_amplitude;
   assign rsp_deriv_sigma     = buf_ff[rp_ff].deriv_sigma;
   assign rsp_deriv_offset    = buf_ff[rp_ff].deriv_offset;
   assign rsp_last_out        = buf_ff[rp_ff].last_out;

endmodule

`default_nettype wire
